// ===== design/etfi_pkg.sv =====
// shared types and constants for the escape-time fractal iterator
// no dependencies
package etfi_pkg;

  // default configuration of the arithmetic and the cycle check
  localparam int COORD_WIDTH       = 32;
  localparam int FRAC_BITS         = 28;
  localparam int ITER_WIDTH        = 16;
  localparam int FIRST_SAVED_MASK  = 7;
  localparam int SAVED_INCR_RELOAD = 4;

  // fixed constants of the algorithm
  localparam int PER_LOOKBACK  = 255;
  localparam int ESC_BACKOFF   = 10;
  localparam int ALT_COLOUR    = 7;
  localparam int COLOUR_OFFSET = 7;

  // register indexes
  localparam logic [2:0] REG_MAX_ITER  = 3'd0;
  localparam logic [2:0] REG_BAILOUT   = 3'd1;
  localparam logic [2:0] REG_CLOSE     = 3'd2;
  localparam logic [2:0] REG_CONST_RE  = 3'd3;
  localparam logic [2:0] REG_CONST_IM  = 3'd4;
  localparam logic [2:0] REG_JULIA     = 3'd5;
  localparam logic [2:0] REG_PER_MODE  = 3'd6;
  localparam logic [2:0] REG_OUT_MODE  = 3'd7;

  // outside colouring modes
  localparam logic [1:0] OUT_COUNT = 2'd0;
  localparam logic [1:0] OUT_REAL  = 2'd1;
  localparam logic [1:0] OUT_IMAG  = 2'd2;
  localparam logic [1:0] OUT_SUM   = 2'd3;

  // cycle check off
  localparam logic [1:0] PER_OFF = 2'd0;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_XX = 2'd0,
    MUL_YY = 2'd1,
    MUL_XY = 2'd2
  } mul_sel_t;

  // controller states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD   = 8'b0000_0010,
    ST_MXX    = 8'b0000_0100,
    ST_MYY    = 8'b0000_1000,
    ST_MXY    = 8'b0001_0000,
    ST_MFIN   = 8'b0010_0000,
    ST_STEP   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cap_x2;
    logic     cap_y2;
    logic     cap_xy2;
    logic     test;
    logic     step;
    logic     dec;
    logic     finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic julia;
    logic hit;
    logic cx_gt1;
    logic out_free;
  } sts_t;

endpackage

// ===== design/etfi_ctrl.sv =====
// controller state machine of the fractal iterator
// depends on etfi_pkg
module etfi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  etfi_pkg::sts_t sts,
  output etfi_pkg::cmd_t cmd
);

  etfi_pkg::state_t state, state_next;
  logic pre, pre_next;
  logic testing, testing_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= etfi_pkg::ST_IDLE;
      pre     <= 1'b0;
      testing <= 1'b0;
    end else begin
      state   <= state_next;
      pre     <= pre_next;
      testing <= testing_next;
    end
  end

  assign in_ready = (state == etfi_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    pre_next     = pre;
    testing_next = testing;
    cmd          = '0;
    cmd.mul_sel  = etfi_pkg::MUL_XX;
    case (state)
      etfi_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = etfi_pkg::ST_LOAD;
        end
      end
      etfi_pkg::ST_LOAD: begin
        pre_next     = sts.julia;
        testing_next = 1'b0;
        state_next   = etfi_pkg::ST_MXX;
      end
      etfi_pkg::ST_MXX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = etfi_pkg::MUL_XX;
        state_next  = etfi_pkg::ST_MYY;
      end
      etfi_pkg::ST_MYY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = etfi_pkg::MUL_YY;
        cmd.cap_x2  = 1'b1;
        state_next  = etfi_pkg::ST_MXY;
      end
      etfi_pkg::ST_MXY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = etfi_pkg::MUL_XY;
        cmd.cap_y2  = 1'b1;
        state_next  = etfi_pkg::ST_MFIN;
      end
      etfi_pkg::ST_MFIN: begin
        cmd.cap_xy2 = 1'b1;
        cmd.test    = testing;
        if (testing && sts.hit) state_next = etfi_pkg::ST_FINISH;
        else state_next = etfi_pkg::ST_STEP;
      end
      etfi_pkg::ST_STEP: begin
        if (pre) begin
          cmd.step   = 1'b1;
          pre_next   = 1'b0;
          state_next = etfi_pkg::ST_MXX;
        end else if (sts.cx_gt1) begin
          cmd.step     = 1'b1;
          cmd.dec      = 1'b1;
          testing_next = 1'b1;
          state_next   = etfi_pkg::ST_MXX;
        end else begin
          state_next = etfi_pkg::ST_FINISH;
        end
      end
      etfi_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = etfi_pkg::ST_IDLE;
        end
      end
      default: state_next = etfi_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/etfi_dp.sv =====
// datapath of the fractal iterator: config registers, shared multiplier,
// orbit registers, cycle check, colouring and result word; uses etfi_pkg
module etfi_dp #(
  parameter int COORD_WIDTH       = etfi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS         = etfi_pkg::FRAC_BITS,
  parameter int ITER_WIDTH        = etfi_pkg::ITER_WIDTH,
  parameter int FIRST_SAVED_MASK  = etfi_pkg::FIRST_SAVED_MASK,
  parameter int SAVED_INCR_RELOAD = etfi_pkg::SAVED_INCR_RELOAD
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] point_real,
  input  logic signed [31:0] point_imag,
  input  logic               restart_periodicity,
  input  etfi_pkg::cmd_t     cmd,
  output etfi_pkg::sts_t     sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        color,
  output logic [15:0]        iterations,
  output logic               escaped,
  output logic               periodic
);

  localparam int W  = COORD_WIDTH;
  localparam int IW = ITER_WIDTH;
  localparam int SW = W + 1;
  localparam int MW = (SW > 31) ? SW : 31;
  localparam int DW = (SW > 29) ? SW : 29;
  localparam int CW = SW + IW + 3;
  localparam int SIW = IW + 2;
  localparam bit SAT64 = (SW > 64);

  // saturate helpers
  function automatic logic signed [W-1:0] sat_sum(input logic signed [SW-1:0] v);
    if (v[SW-1] == v[SW-2]) return v[W-1:0];
    return v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [W-1:0] sat_prod(input logic signed [2*W-1:0] v);
    if (&v[2*W-1:W-1] || ~|v[2*W-1:W-1]) return v[W-1:0];
    return v[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (&e[63:W-1] || ~|e[63:W-1]) return e[W-1:0];
    return e[63] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  function automatic logic signed [W-1:0] addc(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    return sat_sum(SW'(a) + SW'(b));
  endfunction

  // configuration registers
  logic [IW-1:0]      max_iterations;
  logic [30:0]        bailout_limit;
  logic [28:0]        close_enough;
  logic signed [31:0] const_real, const_imag;
  logic               julia_mode;
  logic [1:0]         periodicity_mode, outside_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations   <= IW'(150);
      bailout_limit    <= 31'd1073741824;
      close_enough     <= 29'd268;
      const_real       <= '0;
      const_imag       <= '0;
      julia_mode       <= 1'b0;
      periodicity_mode <= 2'd1;
      outside_mode     <= etfi_pkg::OUT_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        etfi_pkg::REG_MAX_ITER: max_iterations   <= IW'(cfg_data[15:0]);
        etfi_pkg::REG_BAILOUT:  bailout_limit    <= cfg_data[30:0];
        etfi_pkg::REG_CLOSE:    close_enough     <= cfg_data[28:0];
        etfi_pkg::REG_CONST_RE: const_real       <= cfg_data;
        etfi_pkg::REG_CONST_IM: const_imag       <= cfg_data;
        etfi_pkg::REG_JULIA:    julia_mode       <= cfg_data[0];
        etfi_pkg::REG_PER_MODE: periodicity_mode <= cfg_data[1:0];
        etfi_pkg::REG_OUT_MODE: outside_mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // orbit state
  logic signed [W-1:0]   x, y, x2, y2, xy2, cr, ci, sx, sy;
  logic signed [2*W-1:0] p;
  logic [IW-1:0]         cx, start, sand, pstart;
  logic [7:0]            incr;
  logic                  esc_f, per_f;

  // start point of the cycle check
  logic signed [SIW-1:0] st_raw, st_cap, st_cl;
  always_comb begin
    if (periodicity_mode == etfi_pkg::PER_OFF) st_raw = '0;
    else if (restart_periodicity)
      st_raw = SIW'(max_iterations) - SIW'(etfi_pkg::PER_LOOKBACK);
    else st_raw = SIW'(pstart);
    st_cap = SIW'(max_iterations) - SIW'(FIRST_SAVED_MASK);
    st_cl  = (st_raw > st_cap) ? st_cap : st_raw;
    if (st_cl < 0) st_cl = '0;
  end

  // input coordinates
  logic signed [W-1:0] pr, pi, kr, ki;
  assign pr = sat_in(point_real);
  assign pi = sat_in(point_imag);
  assign kr = sat_in(const_real);
  assign ki = sat_in(const_imag);

  // shared multiplier operands
  logic signed [W-1:0] ma, mb;
  always_comb begin
    ma = (cmd.mul_sel == etfi_pkg::MUL_YY) ? y : x;
    mb = (cmd.mul_sel == etfi_pkg::MUL_XX) ? x : y;
  end

  // escape and cycle tests
  logic [MW-1:0]       mag, bail;
  logic                esc_now, in_chk, save_now, per_now;
  logic [IW-1:0]       phase;
  logic signed [SW-1:0] dx, dy;
  logic [DW-1:0]       adx, ady, cls;
  always_comb begin
    mag  = MW'({1'b0, x2}) + MW'({1'b0, y2});
    bail = MW'(bailout_limit);
    esc_now = (mag >= bail);
    in_chk  = (cx < start);
    phase   = max_iterations - cx;
    save_now = in_chk && ((phase & sand) == '0);
    dx  = SW'(sx) - SW'(x);
    dy  = SW'(sy) - SW'(y);
    adx = DW'(dx[SW-1] ? -dx : dx);
    ady = DW'(dy[SW-1] ? -dy : dy);
    cls = DW'(close_enough);
    per_now = in_chk && !save_now && (adx < cls) && (ady < cls);
  end

  assign sts.julia    = julia_mode;
  assign sts.hit      = esc_now || per_now;
  assign sts.cx_gt1   = (cx > IW'(1));
  assign sts.out_free = !out_valid || out_ready;

  // orbit update, multiplier and cycle check registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= max_iterations;
      start <= IW'(st_cl);
      sand  <= IW'(FIRST_SAVED_MASK);
      // first save widens the interval at once
      incr  <= 8'd1;
      esc_f <= 1'b0;
      per_f <= 1'b0;
      sx    <= '0;
      sy    <= '0;
      if (julia_mode) begin
        cr <= kr; ci <= ki; x <= pr; y <= pi;
      end else begin
        cr <= pr; ci <= pi; x <= addc(kr, pr); y <= addc(ki, pi);
      end
    end
    if (cmd.mul_en) p <= ma * mb;
    if (cmd.cap_x2) x2 <= sat_prod(p >>> FRAC_BITS);
    if (cmd.cap_y2) y2 <= sat_prod(p >>> FRAC_BITS);
    if (cmd.cap_xy2) xy2 <= sat_prod(p >>> (FRAC_BITS - 1));
    if (cmd.step) begin
      x <= addc(sat_sum(SW'(x2) - SW'(y2)), cr);
      y <= addc(xy2, ci);
      if (cmd.dec) cx <= cx - IW'(1);
    end
    if (cmd.test) begin
      if (esc_now) esc_f <= 1'b1;
      else if (save_now) begin
        sx <= x;
        sy <= y;
        if (incr == 8'd1) begin
          sand <= {sand[IW-2:0], 1'b1};
          incr <= 8'(SAVED_INCR_RELOAD);
        end else begin
          incr <= incr - 8'd1;
        end
      end else if (per_now) per_f <= 1'b1;
    end
  end

  // escape colouring
  logic [IW-1:0]         cnt;
  logic signed [SW-1:0]  sum_xy, src;
  logic signed [SW:0]    ve, vn, tr;
  logic signed [CW-1:0]  colc;
  logic [IW-1:0]         col;
  always_comb begin
    cnt    = max_iterations - cx;
    sum_xy = SW'(x) + SW'(y);
    if (SAT64) begin
      if (sum_xy > SW'(64'sh7FFF_FFFF_FFFF_FFFF)) sum_xy = SW'(64'sh7FFF_FFFF_FFFF_FFFF);
      if (sum_xy < SW'(-64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1))
        sum_xy = SW'(-64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1);
    end
    case (outside_mode)
      etfi_pkg::OUT_REAL: src = SW'(x);
      etfi_pkg::OUT_IMAG: src = SW'(y);
      default:            src = sum_xy;
    endcase
    ve = (SW + 1)'(src);
    vn = -ve;
    tr = ve[SW] ? -(vn >>> FRAC_BITS) : (ve >>> FRAC_BITS);
    colc = CW'(tr) + CW'($signed({1'b0, cnt}))
         + ((outside_mode != etfi_pkg::OUT_SUM) ? CW'(etfi_pkg::COLOUR_OFFSET) : CW'(0));
    if (outside_mode == etfi_pkg::OUT_COUNT) begin
      col = (cnt == '0) ? IW'(1) : cnt;
    end else if (colc <= 0 || colc > CW'($signed({1'b0, max_iterations}))) begin
      col = IW'(1);
    end else begin
      col = IW'(colc);
    end
  end

  // result word and carried start point
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pstart    <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (esc_f) begin
          pstart <= (cx > IW'(etfi_pkg::ESC_BACKOFF)) ?
                    cx - IW'(etfi_pkg::ESC_BACKOFF) : '0;
        end else begin
          pstart <= max_iterations;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      escaped  <= esc_f;
      periodic <= per_f && !esc_f;
      if (esc_f) begin
        color      <= 16'(col);
        iterations <= 16'(cnt);
      end else begin
        iterations <= 16'(max_iterations);
        if (per_f && periodicity_mode[1]) color <= 16'(etfi_pkg::ALT_COLOUR);
        else color <= 16'(max_iterations);
      end
    end
  end

endmodule

// ===== design/escape_time_fractal_iterator_top.sv =====
// top level of the escape-time fractal iterator
// depends on etfi_pkg, etfi_ctrl and etfi_dp
//
// Each pixel word enters through in_valid/in_ready and gives one result word.
// One shared signed multiplier forms x*x, y*y and 2xy in turn, so one orbit
// step passes through MXX, MYY and MXY (the three products), MFIN (the
// capture/check) and STEP (the update). In Julia mode one extra step is made
// before the count starts, and a pixel ends early when it escapes or a cycle
// is found.
// The next pixel is taken while the previous result waits in the output
// register. Configuration writes are accepted in any cycle and should only
// be made while the block is idle.
module escape_time_fractal_iterator_top #(
  parameter int COORD_WIDTH       = etfi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS         = etfi_pkg::FRAC_BITS,
  parameter int ITER_WIDTH        = etfi_pkg::ITER_WIDTH,
  parameter int FIRST_SAVED_MASK  = etfi_pkg::FIRST_SAVED_MASK,
  parameter int SAVED_INCR_RELOAD = etfi_pkg::SAVED_INCR_RELOAD
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_real,
  input  logic signed [31:0] point_imag,
  input  logic               restart_periodicity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        color,
  output logic [15:0]        iterations,
  output logic               escaped,
  output logic               periodic
);

  etfi_pkg::cmd_t cmd;
  etfi_pkg::sts_t sts;

  // config word always taken
  assign cfg_ready = 1'b1;

  etfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  etfi_dp #(
    .COORD_WIDTH       (COORD_WIDTH),
    .FRAC_BITS         (FRAC_BITS),
    .ITER_WIDTH        (ITER_WIDTH),
    .FIRST_SAVED_MASK  (FIRST_SAVED_MASK),
    .SAVED_INCR_RELOAD (SAVED_INCR_RELOAD)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .point_real          (point_real),
    .point_imag          (point_imag),
    .restart_periodicity (restart_periodicity),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .color               (color),
    .iterations          (iterations),
    .escaped             (escaped),
    .periodic            (periodic)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the escape-time fractal iterator top level
// depends on etfi_pkg and escape_time_fractal_iterator_top; predicts every result word
`timescale 1ns / 1ps

module tb_top;

  localparam int     ONE  = 1 << etfi_pkg::FRAC_BITS;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  typedef struct {
    logic [15:0] color;
    logic [15:0] iterations;
    logic        escaped;
    logic        periodic;
  } pixel_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] point_real = '0;
  logic signed [31:0] point_imag = '0;
  logic               restart_periodicity = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        color;
  logic [15:0]        iterations;
  logic               escaped;
  logic               periodic;

  // shadow copy of the registers and the carried cycle-check start
  longint m_max_iter, m_bailout, m_close, m_kr, m_ki;
  longint m_julia, m_per_mode, m_out_mode, m_per_start;

  pixel_result_t pixel_q[$];
  int  errors = 0;
  int  pixels_sent = 0;
  int  words_checked = 0;
  int  n_escaped = 0;
  int  n_periodic = 0;
  bit  no_idle = 1'b0;

  escape_time_fractal_iterator_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_real(point_real), .point_imag(point_imag),
    .restart_periodicity(restart_periodicity),
    .out_valid(out_valid), .out_ready(out_ready),
    .color(color), .iterations(iterations),
    .escaped(escaped), .periodic(periodic)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sat_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // floor of the product over 2^s, saturated
  function automatic longint fx_mul(longint a, longint b, int s);
    longint p;
    p = a * b;
    return sat_coord(p >>> s);
  endfunction

  function automatic longint int_part(longint v);
    if (v >= 0) return v >>> etfi_pkg::FRAC_BITS;
    return -((-v) >>> etfi_pkg::FRAC_BITS);
  endfunction

  function automatic longint abs_diff(longint a, longint b);
    return a >= b ? a - b : b - a;
  endfunction

  // one pixel through the orbit, updating the carried start point
  function automatic pixel_result_t pixel_predict(longint pr, longint pi, bit restart);
    pixel_result_t r;
    longint maxit, start, cap, cx, x, y, x2, y2, xy2, cr, ci, sx, sy, c, sand;
    int incr;
    bit esc, per;
    maxit = m_max_iter;
    sx = 0; sy = 0; sand = etfi_pkg::FIRST_SAVED_MASK; incr = 1; esc = 0; per = 0;
    start = m_per_start;
    if (m_per_mode == etfi_pkg::PER_OFF) start = 0;
    else if (restart) start = maxit - etfi_pkg::PER_LOOKBACK;
    cap = maxit - etfi_pkg::FIRST_SAVED_MASK;
    if (start > cap) start = cap;
    if (start < 0) start = 0;
    if (m_julia == 0) begin
      cr = pr; ci = pi;
      x = sat_coord(m_kr + pr); y = sat_coord(m_ki + pi);
    end else begin
      cr = m_kr; ci = m_ki;
      x2 = fx_mul(pr, pr, etfi_pkg::FRAC_BITS);
      y2 = fx_mul(pi, pi, etfi_pkg::FRAC_BITS);
      xy2 = fx_mul(pr, pi, etfi_pkg::FRAC_BITS - 1);
      x = sat_coord(sat_coord(x2 - y2) + cr);
      y = sat_coord(xy2 + ci);
    end
    x2 = fx_mul(x, x, etfi_pkg::FRAC_BITS);
    y2 = fx_mul(y, y, etfi_pkg::FRAC_BITS);
    xy2 = fx_mul(x, y, etfi_pkg::FRAC_BITS - 1);
    cx = maxit;
    forever begin
      cx--;
      if (cx <= 0) break;
      x = sat_coord(sat_coord(x2 - y2) + cr);
      y = sat_coord(xy2 + ci);
      x2 = fx_mul(x, x, etfi_pkg::FRAC_BITS);
      y2 = fx_mul(y, y, etfi_pkg::FRAC_BITS);
      xy2 = fx_mul(x, y, etfi_pkg::FRAC_BITS - 1);
      if (x2 + y2 >= m_bailout) begin
        esc = 1;
        break;
      end
      if (cx < start) begin
        if (((maxit - cx) & sand) == 0) begin
          sx = x; sy = y;
          incr--;
          if (incr == 0) begin
            if (sand < (64'sd1 << 40)) sand = (sand << 1) | 1;
            incr = etfi_pkg::SAVED_INCR_RELOAD;
          end
        end else if (abs_diff(sx, x) < m_close && abs_diff(sy, y) < m_close) begin
          per = 1;
          break;
        end
      end
    end
    if (esc) begin
      c = maxit - cx;
      m_per_start = (cx - etfi_pkg::ESC_BACKOFF > 0) ? cx - etfi_pkg::ESC_BACKOFF : 0;
      r.iterations = c[15:0];
      case (m_out_mode[1:0])
        etfi_pkg::OUT_COUNT: if (c == 0) c = 1;
        etfi_pkg::OUT_REAL:  c = c + int_part(x) + etfi_pkg::COLOUR_OFFSET;
        etfi_pkg::OUT_IMAG:  c = c + int_part(y) + etfi_pkg::COLOUR_OFFSET;
        etfi_pkg::OUT_SUM:   c = c + int_part(x + y);
        default: ;
      endcase
      if (m_out_mode != etfi_pkg::OUT_COUNT && (c <= 0 || c > maxit)) c = 1;
      r.color = c[15:0];
    end else begin
      m_per_start = maxit;
      r.iterations = maxit[15:0];
      r.color = (per && m_per_mode >= 2) ? 16'(etfi_pkg::ALT_COLOUR) : maxit[15:0];
    end
    m_per_start &= 16'hFFFF;
    r.escaped = esc;
    r.periodic = per;
    return r;
  endfunction

  // random stall on the result side
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 9);
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        e = pixel_q.pop_front();
        words_checked++;
        if (color !== e.color) begin
          $error("color: expected %0d, got %0d", e.color, color); errors++;
        end
        if (iterations !== e.iterations) begin
          $error("iterations: expected %0d, got %0d", e.iterations, iterations); errors++;
        end
        if (escaped !== e.escaped) begin
          $error("escaped: expected %0d, got %0d", e.escaped, escaped); errors++;
        end
        if (periodic !== e.periodic) begin
          $error("periodic: expected %0d, got %0d", e.periodic, periodic); errors++;
        end
      end
    end
  end

  // wait until every result has come back
  task automatic drain();
    wait (pixel_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      etfi_pkg::REG_MAX_ITER: m_max_iter = data[15:0];
      etfi_pkg::REG_BAILOUT:  m_bailout = data[30:0];
      etfi_pkg::REG_CLOSE:    m_close = data[28:0];
      etfi_pkg::REG_CONST_RE: m_kr = longint'(signed'(data));
      etfi_pkg::REG_CONST_IM: m_ki = longint'(signed'(data));
      etfi_pkg::REG_JULIA:    m_julia = data[0];
      etfi_pkg::REG_PER_MODE: m_per_mode = data[1:0];
      etfi_pkg::REG_OUT_MODE: m_out_mode = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(int unsigned maxit, int unsigned bail, int unsigned close_d,
                         int kr, int ki, int julia, int pmode, int omode);
    drain();
    cfg_write(etfi_pkg::REG_MAX_ITER, maxit);
    cfg_write(etfi_pkg::REG_BAILOUT, bail);
    cfg_write(etfi_pkg::REG_CLOSE, close_d);
    cfg_write(etfi_pkg::REG_CONST_RE, kr);
    cfg_write(etfi_pkg::REG_CONST_IM, ki);
    cfg_write(etfi_pkg::REG_JULIA, julia);
    cfg_write(etfi_pkg::REG_PER_MODE, pmode);
    cfg_write(etfi_pkg::REG_OUT_MODE, omode);
  endtask

  // send one pixel word and record its prediction on acceptance
  task automatic send_pixel(logic [31:0] re, logic [31:0] im, bit restart);
    pixel_result_t r;
    while (!no_idle && $urandom_range(99) < 9) @(negedge clk);
    in_valid = 1'b1;
    point_real = re; point_imag = im; restart_periodicity = restart;
    do @(posedge clk); while (!in_ready);
    r = pixel_predict(longint'(signed'(re)), longint'(signed'(im)), restart);
    pixel_q.push_back(r);
    pixels_sent++;
    if (r.escaped) n_escaped++;
    if (r.periodic) n_periodic++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // mostly points near the set, sometimes anything
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(32'h4800_0000) - 32'h2400_0000;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_pixel(rand_coord(), rand_coord(), $urandom_range(3) == 0);
  endtask

  // fixed points at reset settings: origin, cycles, escapes, extremes
  task automatic test_directed();
    send_pixel(0, 0, 0);
    send_pixel(0, 0, 1);
    send_pixel(-ONE, 0, 0);
    send_pixel(-ONE, 0, 1);
    send_pixel(ONE / 4, 0, 0);
    send_pixel(ONE / 2, ONE / 2, 1);
    send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_pixel(32'h8000_0000, 32'h8000_0000, 1);
    send_pixel(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_pixel(-2 * ONE, 0, 1);
    send_pixel(-ONE / 8, ONE * 3 / 4, 0);
    send_pixel(0, -ONE, 1);
  endtask

  // limits of the loop length and the register extremes
  task automatic test_limits();
    set_all(0, 32'h4000_0000, 268, 0, 0, 0, 1, 0);
    send_pixel(0, 0, 1); send_pixel(ONE, ONE, 0);
    set_all(1, 32'h4000_0000, 268, 0, 0, 1, 2, 3);
    send_pixel(0, 0, 1); send_pixel(3 * ONE, 3 * ONE, 0);
    set_all(7, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 3, 1);
    send_pixel(0, 0, 1); send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 0);
    set_all(40, 32'h7FFF_FFFF, 32'h1000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 2);
    send_random(6);
    // escaping points only at the largest limit
    set_all(65535, 32'h4000_0000, 268, 0, 0, 0, 1, 3);
    send_pixel(2 * ONE, 2 * ONE, 1);
    send_pixel(-3 * ONE, ONE, 0);
    send_pixel(32'h7FFF_FFFF, 0, 1);
  endtask

  // every combination of the mode registers
  task automatic test_modes();
    for (int j = 0; j < 2; j++)
      for (int p = 0; p < 4; p++)
        for (int o = 0; o < 4; o++) begin
          set_all($urandom_range(8, 80), 4 * ONE, $urandom_range(4000),
                  j ? -ONE * 3 / 4 + int'($urandom_range(ONE / 4)) : 0,
                  j ? int'($urandom_range(ONE / 4)) : 0, j, p, o);
          send_random(10);
        end
  endtask

  // random settings, phases of random pixels
  task automatic test_random();
    for (int ph = 0; ph < 25; ph++) begin
      no_idle = (ph == 5);
      set_all($urandom_range(3) == 0 ? $urandom_range(1, 200) : $urandom_range(8, 60),
              $urandom_range(3) == 0 ? $urandom & 32'h7FFF_FFFF : 4 * ONE,
              $urandom_range(1) ? $urandom_range(ONE) : $urandom_range(5000),
              $urandom_range(1) ? $urandom : rand_coord() / 4,
              $urandom_range(1) ? $urandom : rand_coord() / 4,
              $urandom_range(1), $urandom_range(3), $urandom_range(3));
      send_random(50);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    m_max_iter = 150; m_bailout = 32'h4000_0000; m_close = 268;
    m_kr = 0; m_ki = 0; m_julia = 0; m_per_mode = 1; m_out_mode = 0;
    m_per_start = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_limits();
    test_modes();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d pixels, %0d results checked (%0d escaped, %0d periodic)",
             pixels_sent, words_checked, n_escaped, n_periodic);
    if (pixel_q.size() != 0) begin
      $error("%0d predicted results never arrived", pixel_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
